/* src/csc_pkg.sv */
// Shared types, constants and tables for the CORDIC sine/cosine block.
// Holds the arctangent table, the microcode program and the control structs.
// No dependencies.
`default_nettype none

package csc_pkg;

  // Field and register widths
  localparam int ANGLE_W = 7;
  localparam int OUT_W   = 26;
  localparam int CFG_W   = 6;

  // Parameter defaults
  localparam int MAX_ITERATIONS_DEF = 32;
  localparam int FRACTION_BITS_DEF  = 24;

  // Reset value of the iteration count register
  localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

  // Table scaling: degrees times 2^ROM_BITS
  localparam int ROM_BITS   = 24;
  localparam int ROM_SIZE   = 32;
  localparam int ROM_IDX_W  = $clog2(ROM_SIZE);
  localparam logic [ROM_BITS-1:0] GAIN_ROM = 24'h9B74ED;

  // atan(2^-i) in degrees times 2^24, truncated toward zero
  localparam logic [31:0] ANGLE_ROM [ROM_SIZE] = '{
    32'd754974720, 32'd445687601, 32'd235489088, 32'd119537938,
    32'd60000934,  32'd30029716,  32'd15018522,  32'd7509719,
    32'd3754917,   32'd1877465,   32'd938733,    32'd469366,
    32'd234683,    32'd117341,    32'd58670,     32'd29335,
    32'd14667,     32'd7333,      32'd3666,      32'd1833,
    32'd916,       32'd458,       32'd229,       32'd114,
    32'd57,        32'd28,        32'd14,        32'd7,
    32'd3,         32'd1,         32'd0,         32'd0
  };

  // Datapath operation selected by a control word
  typedef enum logic [1:0] {
    OP_NOP    = 2'd0,
    OP_LOAD   = 2'd1,
    OP_ROTATE = 2'd2,
    OP_EMIT   = 2'd3
  } op_t;

  // Sequencer conditions
  typedef enum logic [2:0] {
    COND_NEVER      = 3'd0,
    COND_ALWAYS     = 3'd1,
    COND_IN_VALID   = 3'd2,
    COND_ZERO_ITERS = 3'd3,
    COND_LAST_FREE  = 3'd4,
    COND_OUT_FREE   = 3'd5
  } cond_t;

  localparam int UPC_W    = 2;
  localparam int UC_DEPTH = 4;

  typedef logic [UPC_W-1:0] upc_t;

  // Microcode addresses
  localparam upc_t UA_WAIT  = 2'd0;
  localparam upc_t UA_ROT   = 2'd1;
  localparam upc_t UA_EMIT  = 2'd2;
  localparam upc_t UA_SPARE = 2'd3;

  // One control word: stay until leave holds, then go to branch_addr
  // when branch holds, else to next_addr.
  typedef struct packed {
    op_t   op;
    cond_t leave;
    cond_t branch;
    upc_t  branch_addr;
    upc_t  next_addr;
  } uword_t;

  localparam uword_t UCODE [UC_DEPTH] = '{
    // wait for an angle, load the datapath on acceptance
    '{op: OP_LOAD,   leave: COND_IN_VALID,  branch: COND_ZERO_ITERS,
      branch_addr: UA_EMIT, next_addr: UA_ROT},
    // micro-rotations, the last one writes the output register
    '{op: OP_ROTATE, leave: COND_LAST_FREE, branch: COND_NEVER,
      branch_addr: UA_WAIT, next_addr: UA_WAIT},
    // no rotations: hand out the start vector
    '{op: OP_EMIT,   leave: COND_OUT_FREE,  branch: COND_NEVER,
      branch_addr: UA_WAIT, next_addr: UA_WAIT},
    // unused address falls back to wait
    '{op: OP_NOP,    leave: COND_ALWAYS,    branch: COND_NEVER,
      branch_addr: UA_WAIT, next_addr: UA_WAIT}
  };

  // Strobes from sequencer to datapath
  typedef struct packed {
    logic in_ready;
    logic load;
    logic rotate;
    logic emit_rot;
    logic emit_gain;
  } ctrl_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic last;
    logic out_free;
    logic zero_iters;
  } stat_t;

endpackage

`default_nettype wire

/* src/csc_sequencer.sv */
// Microcoded sequencer for the CORDIC block: program counter over the
// control ROM in csc_pkg, condition select and strobe decode.
`default_nettype none

module csc_sequencer (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire csc_pkg::stat_t stat,
  output csc_pkg::ctrl_t      ctrl
);

  csc_pkg::upc_t   pc_r;
  csc_pkg::upc_t   pc_nxt;
  csc_pkg::uword_t uw;

  function automatic logic cond_met(input csc_pkg::cond_t c, input logic iv,
                                    input csc_pkg::stat_t s);
    logic r;
    unique case (c)
      csc_pkg::COND_NEVER:      r = 1'b0;
      csc_pkg::COND_ALWAYS:     r = 1'b1;
      csc_pkg::COND_IN_VALID:   r = iv;
      csc_pkg::COND_ZERO_ITERS: r = s.zero_iters;
      csc_pkg::COND_LAST_FREE:  r = s.last && s.out_free;
      csc_pkg::COND_OUT_FREE:   r = s.out_free;
      default:                  r = 1'b0;
    endcase
    return r;
  endfunction

  // fetch the current control word
  assign uw = csc_pkg::UCODE[pc_r];

  // decode strobes
  always_comb begin
    ctrl.in_ready  = (uw.op == csc_pkg::OP_LOAD);
    ctrl.load      = (uw.op == csc_pkg::OP_LOAD) && in_valid;
    ctrl.rotate    = (uw.op == csc_pkg::OP_ROTATE) && (!stat.last || stat.out_free);
    ctrl.emit_rot  = (uw.op == csc_pkg::OP_ROTATE) && stat.last && stat.out_free;
    ctrl.emit_gain = (uw.op == csc_pkg::OP_EMIT) && stat.out_free;
  end

  // select the next step
  always_comb begin
    pc_nxt = pc_r;
    if (cond_met(uw.leave, in_valid, stat)) begin
      if (cond_met(uw.branch, in_valid, stat)) begin
        pc_nxt = uw.branch_addr;
      end else begin
        pc_nxt = uw.next_addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= csc_pkg::UA_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/csc_datapath.sv */
// CORDIC datapath: x/y/angle-sum registers, one shared shift-add unit,
// step counter and output register. Uses csc_pkg tables and structs.
`default_nettype none

module csc_datapath #(
  parameter int MAX_ITERATIONS = csc_pkg::MAX_ITERATIONS_DEF,
  parameter int FRACTION_BITS  = csc_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire csc_pkg::ctrl_t                        ctrl,
  input  wire logic [$clog2(MAX_ITERATIONS+1)-1:0]   iter_cnt,
  input  wire logic [csc_pkg::ANGLE_W-1:0]           in_angle_deg,
  input  wire logic                                  out_stall,
  output csc_pkg::stat_t                             stat,
  output logic                                       out_valid,
  output logic signed [csc_pkg::OUT_W-1:0]           out_sine,
  output logic signed [csc_pkg::OUT_W-1:0]           out_cosine
);

  localparam int IDX_W = $clog2(MAX_ITERATIONS);
  localparam int CNT_W = $clog2(MAX_ITERATIONS+1);
  localparam int XY_W  = FRACTION_BITS + 4;
  localparam int SUM_W = FRACTION_BITS + 9;
  localparam int ROM_SHIFT = csc_pkg::ROM_BITS - FRACTION_BITS;
  localparam logic signed [XY_W-1:0] GAIN = XY_W'(csc_pkg::GAIN_ROM >> ROM_SHIFT);

  logic signed [XY_W-1:0]  x_r, x_nxt;
  logic signed [XY_W-1:0]  y_r, y_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic signed [SUM_W-1:0] target_r;
  logic [IDX_W-1:0]        i_r;
  logic [IDX_W-1:0]        n_last_r;
  logic                    out_valid_r;
  logic signed [csc_pkg::OUT_W-1:0] sine_r, cosine_r;

  logic signed [XY_W-1:0]  xs, ys;
  logic signed [SUM_W-1:0] step;
  logic                    dir_pos;
  logic                    out_free;

  // one micro-rotation
  always_comb begin
    step    = SUM_W'(csc_pkg::ANGLE_ROM[csc_pkg::ROM_IDX_W'(i_r)] >> ROM_SHIFT);
    xs      = x_r >>> i_r;
    ys      = y_r >>> i_r;
    dir_pos = target_r > sum_r;
    if (dir_pos) begin
      x_nxt   = x_r - ys;
      y_nxt   = y_r + xs;
      sum_nxt = sum_r + step;
    end else begin
      x_nxt   = x_r + ys;
      y_nxt   = y_r - xs;
      sum_nxt = sum_r - step;
    end
  end

  assign out_free        = !out_valid_r || !out_stall;
  assign stat.out_free   = out_free;
  assign stat.last       = (i_r == n_last_r);
  assign stat.zero_iters = (iter_cnt == '0);

  // load the start vector or advance one rotation
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x_r      <= GAIN;
      y_r      <= '0;
      sum_r    <= '0;
      target_r <= SUM_W'({in_angle_deg, {FRACTION_BITS{1'b0}}});
      i_r      <= '0;
      n_last_r <= IDX_W'(iter_cnt - CNT_W'(1));
    end else if (ctrl.rotate) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      sum_r <= sum_nxt;
      i_r   <= i_r + IDX_W'(1);
    end
  end

  // capture the result word
  always_ff @(posedge clk) begin
    if (ctrl.emit_rot) begin
      sine_r   <= csc_pkg::OUT_W'(y_nxt);
      cosine_r <= csc_pkg::OUT_W'(x_nxt);
    end else if (ctrl.emit_gain) begin
      sine_r   <= csc_pkg::OUT_W'(y_r);
      cosine_r <= csc_pkg::OUT_W'(x_r);
    end
  end

  // hold valid until the word is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.emit_rot || ctrl.emit_gain) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sine   = sine_r;
  assign out_cosine = cosine_r;

endmodule

`default_nettype wire

/* src/cordic_sine_cosine.sv */
// CORDIC sine/cosine, rotation mode, top level.
// Holds the iteration count register and connects the sequencer and datapath.
//
// Usage:
//   in_valid / in_stall / in_angle_deg carry one angle word in whole degrees.
//   out_valid / out_stall / out_sine / out_cosine return one word per angle,
//   both scaled by 2^FRACTION_BITS. cfg_wr_en / cfg_wr_data write the
//   iteration count n (saturated to MAX_ITERATIONS); write it only while idle.
// Timing:
//   An angle is accepted in the wait step of the microcode program, which also
//   loads the datapath. The shared shift-add unit then runs n micro-rotations,
//   one per cycle until the last, which waits for a free output register and
//   writes it. A new angle is taken only once the result word is written. With
//   n = 0 the start vector is emitted directly.
// Reset:
//   Synchronous rst_n returns the sequencer to the wait step, drops out_valid
//   and sets n to 32.
// Stall:
//   A pending word holds while out_stall is high; the last rotation waits for
//   the output register to free, and no new angle is taken meanwhile.
`default_nettype none

module cordic_sine_cosine #(
  parameter int MAX_ITERATIONS = csc_pkg::MAX_ITERATIONS_DEF,
  parameter int FRACTION_BITS  = csc_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [csc_pkg::CFG_W-1:0]         cfg_wr_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [csc_pkg::ANGLE_W-1:0]       in_angle_deg,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [csc_pkg::OUT_W-1:0]       out_sine,
  output logic signed [csc_pkg::OUT_W-1:0]       out_cosine
);

  localparam int CNT_W = $clog2(MAX_ITERATIONS+1);

  logic [csc_pkg::CFG_W-1:0] iter_cfg_r;
  logic [CNT_W-1:0]          iter_cnt;
  csc_pkg::ctrl_t            ctrl;
  csc_pkg::stat_t            stat;

  // iteration count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_cfg_r <= csc_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      iter_cfg_r <= cfg_wr_data;
    end
  end

  // saturate to the table depth in use
  assign iter_cnt = (int'(iter_cfg_r) > MAX_ITERATIONS) ? CNT_W'(MAX_ITERATIONS)
                                                        : CNT_W'(iter_cfg_r);

  assign in_stall = !ctrl.in_ready;

  csc_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  csc_datapath #(
    .MAX_ITERATIONS (MAX_ITERATIONS),
    .FRACTION_BITS  (FRACTION_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .iter_cnt     (iter_cnt),
    .in_angle_deg (in_angle_deg),
    .out_stall    (out_stall),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_sine     (out_sine),
    .out_cosine   (out_cosine)
  );

  // after taking an angle the block is busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("angle accepted back to back");

  // a result word is only written into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.emit_rot || ctrl.emit_gain) |-> (!out_valid || !out_stall))
    else $error("pending result overwritten");

  // load, rotate and direct emit never coincide
  a_strobe_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctrl.load, ctrl.rotate, ctrl.emit_gain}))
    else $error("conflicting datapath strobes");

  // a new result appears only after an emit strobe
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(ctrl.emit_rot || ctrl.emit_gain))
    else $error("result valid without emit");

endmodule

`default_nettype wire

/* tb/sv/tb_cordic_sine_cosine.sv */
// Self-checking regression for the CORDIC sine/cosine block (cordic_sine_cosine).
// Builds its own arctangent table and rotation predictor and checks every result word.
// Depends on csc_pkg for the port widths only.

module tb_cordic_sine_cosine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC           = 24;
  localparam int MAX_ITER       = 32;
  localparam int TABLE_SIZE     = 32;
  localparam int TABLE_FRAC     = 24;
  localparam int START_GAIN     = 'h9B74ED;
  localparam int ITER_RESET     = 32;
  localparam int DRAIN_CYCLES   = 40;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic signed [csc_pkg::OUT_W-1:0] sine;
    logic signed [csc_pkg::OUT_W-1:0] cosine;
  } trig_word_t;

  logic                             clk;
  logic                             rst_n        = 1'b0;
  logic                             cfg_wr_en    = 1'b0;
  logic [csc_pkg::CFG_W-1:0]        cfg_wr_data  = '0;
  logic                             in_valid     = 1'b0;
  logic                             in_stall;
  logic [csc_pkg::ANGLE_W-1:0]      in_angle_deg = '0;
  logic                             out_valid;
  logic                             out_stall    = 1'b0;
  logic signed [csc_pkg::OUT_W-1:0] out_sine;
  logic signed [csc_pkg::OUT_W-1:0] out_cosine;

  // Stimulus and expectation stores
  logic [csc_pkg::ANGLE_W-1:0] angle_q[$];
  trig_word_t                  trig_expected_q[$];
  logic [31:0]                 atan_deg_table[TABLE_SIZE];
  logic [csc_pkg::CFG_W-1:0]   iter_count = csc_pkg::CFG_W'(ITER_RESET);

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int hold_off_req       = 0;
  int hold_off_seen      = 0;
  int hold_off_left      = 0;
  int failures           = 0;
  int angles_sent        = 0;
  int results_checked    = 0;
  int settings_used      = 1;
  int idle_cycles        = 0;

  cordic_sine_cosine dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_angle_deg (in_angle_deg),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_sine     (out_sine),
    .out_cosine   (out_cosine)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // atan(1/n) in Q62 by the alternating series, n >= 2
  function automatic longint unsigned atan_recip_q62(input longint unsigned n);
    longint unsigned p;
    longint unsigned acc;
    longint unsigned term;
    int k;
    p = (64'd1 << 62) / n;
    acc = 0;
    k = 0;
    while (p != 0) begin
      term = p / (2 * k + 1);
      if (k % 2 == 0) acc += term;
      else acc -= term;
      p = p / (n * n);
      k++;
    end
    return acc;
  endfunction

  // atan(2^-i) in Q62, i >= 1
  function automatic longint unsigned atan_pow2_q62(input int i);
    longint unsigned acc;
    longint unsigned term;
    int k;
    int e;
    acc = 0;
    k = 0;
    e = i;
    while (e <= 62) begin
      term = (64'd1 << (62 - e)) / (2 * k + 1);
      if (k % 2 == 0) acc += term;
      else acc -= term;
      k++;
      e = i * (2 * k + 1);
    end
    return acc;
  endfunction

  // Rotate the gain vector toward the target angle, one step per iteration
  function automatic trig_word_t cordic_predict(
    input logic [csc_pkg::ANGLE_W-1:0] angle,
    input logic [csc_pkg::CFG_W-1:0]   count
  );
    longint     target;
    longint     acc;
    longint     x;
    longint     y;
    longint     xs;
    longint     ys;
    longint     step;
    int         steps;
    trig_word_t w;
    target = longint'(angle) <<< FRAC;
    acc    = 0;
    x      = longint'(START_GAIN) >>> (TABLE_FRAC - FRAC);
    y      = 0;
    steps  = (int'(count) > MAX_ITER) ? MAX_ITER : int'(count);
    for (int i = 0; i < steps; i++) begin
      step = longint'(atan_deg_table[i] >> (TABLE_FRAC - FRAC));
      xs   = x >>> i;
      ys   = y >>> i;
      if (target > acc) begin
        x   = x - ys;
        y   = y + xs;
        acc = acc + step;
      end else begin
        x   = x + ys;
        y   = y - xs;
        acc = acc - step;
      end
    end
    w.sine   = y[csc_pkg::OUT_W-1:0];
    w.cosine = x[csc_pkg::OUT_W-1:0];
    return w;
  endfunction

  task automatic note_failure(input string what);
    failures++;
    if (failures <= REPORT_LIMIT) $display("[%0t] ERROR: %s", $realtime, what);
  endtask

  // Sender: take an accepted word, then offer the next one or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        trig_expected_q.push_back(cordic_predict(in_angle_deg, iter_count));
        angles_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (angle_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid     <= 1'b1;
          in_angle_deg <= angle_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_off_req != hold_off_seen) begin
      hold_off_seen <= hold_off_req;
      hold_off_left <= LONG_HOLD;
      out_stall     <= 1'b1;
    end else if (hold_off_left > 0) begin
      hold_off_left <= hold_off_left - 1;
      out_stall     <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Check each accepted result word against the oldest expectation
  always @(posedge clk) begin
    trig_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (trig_expected_q.size() == 0) begin
        note_failure($sformatf("unexpected result word sine=%0d cosine=%0d",
                               out_sine, out_cosine));
      end else begin
        want = trig_expected_q.pop_front();
        results_checked++;
        if (out_sine !== want.sine)
          note_failure($sformatf("sine: expected %0d, got %0d", want.sine, out_sine));
        if (out_cosine !== want.cosine)
          note_failure($sformatf("cosine: expected %0d, got %0d", want.cosine, out_cosine));
      end
    end
  end

  // Watchdog: count cycles with work pending and nothing moving
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (!in_valid && trig_expected_q.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("cordic_sine_cosine regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Wait until every queued angle has produced its result, then let the block settle
  task automatic wait_for_idle();
    @(negedge clk);
    while (angle_q.size() != 0 || in_valid || trig_expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input bit write_cfg, input int cfg_value, input int n_items,
                           input int idle_pct, input int stall_pct, input bit long_hold);
    if (write_cfg) begin
      @(posedge clk);
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= cfg_value[csc_pkg::CFG_W-1:0];
      @(posedge clk);
      cfg_wr_en   <= 1'b0;
      iter_count  = cfg_value[csc_pkg::CFG_W-1:0];
      settings_used++;
    end
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    // Mostly angles in the quarter circle, the rest above ninety
    repeat (n_items) begin
      if ($urandom_range(99) < 85)
        angle_q.push_back(csc_pkg::ANGLE_W'($urandom_range(90)));
      else
        angle_q.push_back(csc_pkg::ANGLE_W'($urandom_range(127, 91)));
    end
    if (long_hold) hold_off_req++;
    wait_for_idle();
  endtask

  initial begin
    longint unsigned quarter_pi;
    logic [127:0]    scaled;
    int              directed[$];

    // Build the arctangent table in degrees times 2^24, truncated
    quarter_pi = 4 * atan_recip_q62(5) - atan_recip_q62(239);
    atan_deg_table[0] = 32'd45 << TABLE_FRAC;
    for (int i = 1; i < TABLE_SIZE; i++) begin
      scaled = 128'(atan_pow2_q62(i));
      scaled = scaled * (128'd45 << TABLE_FRAC);
      scaled = scaled / quarter_pi;
      atan_deg_table[i] = scaled[31:0];
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, quadrant corners and angles past ninety
    directed = '{0, 90, 1, 89, 2, 88, 30, 45, 60, 63, 64, 91, 99, 100, 110, 127};
    foreach (directed[i]) angle_q.push_back(csc_pkg::ANGLE_W'(directed[i]));
    wait_for_idle();

    // Sweep the iteration count and the idle patterns
    run_phase(1'b1, 0,                       60,  0,  0,  1'b0);
    run_phase(1'b1, 63,                      60,  48, 0,  1'b0);
    run_phase(1'b1, 1,                       60,  0,  48, 1'b0);
    run_phase(1'b1, 33,                      60,  35, 35, 1'b0);
    run_phase(1'b1, $urandom_range(31, 2),   100, 48, 0,  1'b0);
    run_phase(1'b1, 32,                      150, 0,  0,  1'b1);
    run_phase(1'b0, 32,                      150, 0,  48, 1'b0);
    run_phase(1'b1, $urandom_range(31, 2),   150, 35, 35, 1'b0);

    if (trig_expected_q.size() != 0)
      note_failure($sformatf("%0d results never arrived", trig_expected_q.size()));

    $display("covered %0d angles over %0d iteration settings, %0d results checked",
             angles_sent, settings_used, results_checked);
    $display("idle patterns: none, sender gaps, receiver stalls, both, long hold-off");
    if (failures == 0) begin
      $display("cordic_sine_cosine regression: pass");
    end else begin
      $display("%0d failures", failures);
      $display("cordic_sine_cosine regression: fail");
    end
    $finish;
  end

endmodule

/* files.f */
src/csc_pkg.sv
src/csc_sequencer.sv
src/csc_datapath.sv
src/cordic_sine_cosine.sv
tb/sv/tb_cordic_sine_cosine.sv
